@@ sv/ultrasonic_echo_ranger_unit_defines.svh @@
// Assertion macros shared by the ultrasonic echo ranger modules
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define UER_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/uer_pkg.sv @@
// Types and constants for the ultrasonic echo ranger
package uer_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int EXT_W       = 32;
    localparam int DIV_STEPS   = 16;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOO_FAR_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM  = 2'd2;

    // Register reset values
    localparam logic [7:0]  RST_TRIGGER_TICKS = 8'd16;
    localparam logic [15:0] RST_TOO_FAR_LIMIT = 16'd4000;
    localparam logic [7:0]  RST_TICKS_PER_CM  = 8'd58;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_FAR = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Measurement phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT_START,
        PH_WAIT_STOP
    } t_phase;

    // Handshake controller state
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_sts;

endpackage

@@ sv/uer_if.sv @@
// Item and configuration channel interfaces
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;
    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trigger_out;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] echo_width;
    logic [15:0] distance_cm;
    modport source (output valid, output trigger_out, output done_res, output status,
                    output echo_width, output distance_cm, input ready);
    modport sink (input valid, input trigger_out, input done_res, input status,
                  input echo_width, input distance_cm, output ready);
endinterface

interface uer_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/uer_ctrl.sv @@
// Handshake controller: sequences item acceptance, division and result hold
`include "ultrasonic_echo_ranger_unit_defines.svh"

module uer_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  uer_pkg::t_sts i_sts,
    output uer_pkg::t_cmd o_cmd
);
    import uer_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        n_state     = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        accept = i_in_valid && o_in_ready;
        // Take a new item: divide first when a distance is due
        if (accept) begin
            n_state = i_sts.need_div ? S_DIV : S_HOLD;
        end
        o_cmd.load = accept;
        o_cmd.step = (r_state == S_DIV);
    end

    `UER_ASSERT_NEXT(a_div_hides_result, accept && i_sts.need_div, !o_out_valid, "result shown before division")
    `UER_ASSERT_NEXT(a_plain_result, accept && !i_sts.need_div, o_out_valid, "plain result not shown next cycle")
    `UER_ASSERT_NEXT(a_div_ends, (r_state == S_DIV) && i_sts.div_last, o_out_valid, "division end without result")

endmodule

@@ sv/uer_dp.sv @@
// Datapath: config registers, measurement phase, result register, divider
`include "ultrasonic_echo_ranger_unit_defines.svh"

module uer_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_start_req,
    input  logic                           i_echo_level,
    input  uer_pkg::t_cmd                  i_cmd,
    output uer_pkg::t_sts                  o_sts,
    output logic                           o_trigger_out,
    output logic                           o_done_res,
    output logic [1:0]                     o_status,
    output logic [15:0]                    o_echo_width,
    output logic [15:0]                    o_distance_cm
);
    import uer_pkg::*;

    // Configuration
    logic [7:0]  r_trigger_ticks;
    logic [15:0] r_too_far_limit;
    logic [7:0]  r_ticks_per_cm;

    // Measurement state
    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick_count, n_tick_count;
    logic                   r_echo_prev;

    // Result and divider
    logic              r_trig, n_trig;
    logic              r_done, n_done;
    logic [1:0]        r_status, n_status;
    logic [15:0]       r_width, n_width;
    logic [15:0]       r_quo;
    logic [7:0]        r_rem;
    logic [7:0]        r_div;
    logic [STEP_W-1:0] r_step;

    logic                   edge_seen;
    logic [7:0]             trig_len;
    logic [7:0]             div_val;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [EXT_W-1:0]       cnt_ext;
    logic                   need_div;
    logic [8:0]             rem_sh;
    logic                   rem_ge;

    // Config writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= RST_TRIGGER_TICKS;
            r_too_far_limit <= RST_TOO_FAR_LIMIT;
            r_ticks_per_cm  <= RST_TICKS_PER_CM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg_data[7:0];
                CFG_TOO_FAR_LIMIT: r_too_far_limit <= i_cfg_data;
                CFG_TICKS_PER_CM:  r_ticks_per_cm  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // One tick of the measurement
    always_comb begin
        edge_seen    = (i_echo_level != r_echo_prev);
        trig_len     = (r_trigger_ticks == 8'd0) ? 8'd1 : r_trigger_ticks;
        div_val      = (r_ticks_per_cm == 8'd0) ? 8'd1 : r_ticks_per_cm;
        tick_inc     = (r_tick_count != {COUNT_WIDTH{1'b1}}) ?
                       r_tick_count + COUNT_WIDTH'(1) : r_tick_count;
        cnt_ext      = EXT_W'(r_tick_count);
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_trig       = 1'b0;
        n_done       = 1'b0;
        n_status     = ST_OK;
        n_width      = 16'd0;
        need_div     = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_trig = 1'b1;
                    if (trig_len == 8'd1) begin
                        n_phase      = PH_WAIT_START;
                        n_tick_count = '0;
                    end else begin
                        n_phase      = PH_TRIG;
                        n_tick_count = COUNT_WIDTH'(1);
                    end
                end
            end
            PH_TRIG: begin
                if (edge_seen) begin
                    n_done       = 1'b1;
                    n_status     = ST_ERROR;
                    n_phase      = PH_IDLE;
                    n_tick_count = '0;
                end else begin
                    n_trig = 1'b1;
                    if (EXT_W'(tick_inc) >= EXT_W'(trig_len)) begin
                        n_phase      = PH_WAIT_START;
                        n_tick_count = '0;
                    end else begin
                        n_tick_count = tick_inc;
                    end
                end
            end
            PH_WAIT_START: begin
                if (edge_seen && i_echo_level) begin
                    n_phase      = PH_WAIT_STOP;
                    n_tick_count = COUNT_WIDTH'(1);
                end
            end
            PH_WAIT_STOP: begin
                if (i_echo_level) begin
                    n_tick_count = tick_inc;
                end else begin
                    n_done       = 1'b1;
                    n_width      = (cnt_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
                    n_status     = (cnt_ext > EXT_W'(r_too_far_limit)) ? ST_TOO_FAR : ST_OK;
                    need_div     = (n_status == ST_OK);
                    n_phase      = PH_IDLE;
                    n_tick_count = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        o_sts.need_div = need_div;
        o_sts.div_last = (r_step == STEP_W'(DIV_STEPS - 1));
    end

    // Restoring division step: one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[15]};
        rem_ge = (rem_sh >= {1'b0, r_div});
    end

    // Measurement state advances on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_echo_prev  <= 1'b0;
        end else if (i_cmd.load) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_echo_prev  <= i_echo_level;
        end
    end

    // Result register; the quotient register doubles as distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig   <= 1'b0;
            r_done   <= 1'b0;
            r_status <= ST_OK;
            r_width  <= 16'd0;
            r_quo    <= 16'd0;
            r_rem    <= 8'd0;
            r_div    <= 8'd1;
            r_step   <= '0;
        end else if (i_cmd.load) begin
            r_trig   <= n_trig;
            r_done   <= n_done;
            r_status <= n_status;
            r_width  <= n_width;
            r_quo    <= need_div ? n_width : 16'd0;
            r_rem    <= 8'd0;
            r_div    <= div_val;
            r_step   <= '0;
        end else if (i_cmd.step) begin
            r_quo  <= {r_quo[14:0], rem_ge};
            r_rem  <= rem_ge ? 8'(rem_sh - {1'b0, r_div}) : rem_sh[7:0];
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_trigger_out = r_trig;
    assign o_done_res    = r_done;
    assign o_status      = r_status;
    assign o_echo_width  = r_width;
    assign o_distance_cm = r_quo;

    `UER_ASSERT_SAME(a_trig_not_done, r_trig, !r_done, "trigger high on a finishing tick")
    `UER_ASSERT_SAME(a_error_no_width, r_status == ST_ERROR, (r_width == 16'd0) && (r_quo == 16'd0), "error result carries data")
    `UER_ASSERT_NEXT(a_div_restart, i_cmd.load && need_div, r_step == '0, "division counter not restarted")

endmodule

@@ sv/ultrasonic_echo_ranger_unit.sv @@
// Top level of the ultrasonic echo ranger
//
// Use: each item on i_in is one microsecond tick carrying start_req and the
// sampled echo level. Every accepted item yields exactly one result item on
// o_out: the trigger level to drive this tick, done_res on the tick a
// measurement ends, status (ok, too far, echo edge during trigger), the echo
// width in ticks and the distance in centimetres.
// i_cfg writes trigger_ticks (0), too_far_limit (1) and ticks_per_cm (2); it
// is always ready and should be used only while the block is idle.
// A result is registered and shown in the cycle after its item is accepted;
// a tick that ends an in-range echo first runs through the 16 quotient-bit
// steps of the serial divider. One item is processed at a time, so no new
// item is accepted until the result of the last one is taken.
// A held result does not block: the next item is accepted on the same edge
// the result is taken. While the receiver stalls, the result holds and
// i_in.ready stays low.
// Reset: synchronous active low; restores register defaults (16, 4000, 58),
// returns the measurement to idle and clears the held result.
module ultrasonic_echo_ranger_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    uer_in_if.sink    i_in,
    uer_out_if.source o_out,
    uer_cfg_if.sink   i_cfg
);
    import uer_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Config channel never stalls
    assign i_cfg.ready = 1'b1;

    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    uer_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_start_req   (i_in.start_req),
        .i_echo_level  (i_in.echo_level),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_trigger_out (o_out.trigger_out),
        .o_done_res    (o_out.done_res),
        .o_status      (o_out.status),
        .o_echo_width  (o_out.echo_width),
        .o_distance_cm (o_out.distance_cm)
    );

endmodule
